// ----- hw/rtl/bidirectional_map_table_assert.svh -----
// ----------------------------------------------------------------------------
// Bidirectional map table assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef BIDIRECTIONAL_MAP_TABLE_ASSERT_SVH
`define BIDIRECTIONAL_MAP_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising clock edge outside reset
`define BMT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bmt assertion failed");

// Expression must never be true outside reset
`define BMT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bmt forbidden condition seen");

`else

`define BMT_ASSERT(lbl, clk, rst_n, prop)
`define BMT_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- hw/rtl/bmt_pkg.sv -----
// ----------------------------------------------------------------------------
// Bidirectional map table package
// Field widths, operation and status codes, and the request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package bmt_pkg;

  localparam int OpBits       = 3;
  localparam int KeyInBits    = 16;
  localparam int ValueInBits  = 16;
  localparam int StatusBits   = 2;

  localparam int EntriesDefault   = 16;
  localparam int KeyBitsDefault   = 16;
  localparam int ValueBitsDefault = 16;

  typedef enum logic [OpBits-1:0] {
    OP_INSERT       = 3'd0,
    OP_GET_KEY      = 3'd1,
    OP_GET_VALUE    = 3'd2,
    OP_REMOVE_KEY   = 3'd3,
    OP_REMOVE_VALUE = 3'd4
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [OpBits-1:0]      op;
    logic [KeyInBits-1:0]   key;
    logic [ValueInBits-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [KeyInBits-1:0]   key;
    logic [ValueInBits-1:0] value;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmt_if.sv -----
// ----------------------------------------------------------------------------
// Bidirectional map table channels
// Request and response valid/ready interfaces with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmt_req_if;
  import bmt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OpBits-1:0]      operation;
  logic [KeyInBits-1:0]   key_in;
  logic [ValueInBits-1:0] value_in;

  modport source (output valid, output operation, output key_in, output value_in,
                  input ready);
  modport sink   (input valid, input operation, input key_in, input value_in,
                  output ready);
endinterface

interface bmt_rsp_if;
  import bmt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StatusBits-1:0]  status;
  logic [KeyInBits-1:0]   key_out;
  logic [ValueInBits-1:0] value_out;

  modport source (output valid, output status, output key_out, output value_out,
                  input ready);
  modport sink   (input valid, input status, input key_out, input value_out,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bmt_cam.sv -----
// ----------------------------------------------------------------------------
// Bidirectional map table CAM
// Entry storage with parallel key and value match, slot allocation and update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bidirectional_map_table_assert.svh"

module bmt_cam #(
  parameter int ENTRIES    = bmt_pkg::EntriesDefault,
  parameter int KEY_BITS   = bmt_pkg::KeyBitsDefault,
  parameter int VALUE_BITS = bmt_pkg::ValueBitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire bmt_pkg::req_t req_i,
  output bmt_pkg::rsp_t      rsp_o
);
  import bmt_pkg::*;

  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] value_q [ENTRIES];

  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic [ENTRIES-1:0]    key_hit_raw, value_hit_raw;
  logic [ENTRIES-1:0]    key_hit, value_hit;
  logic [ENTRIES-1:0]    valid_freed, free_vec, slot;
  logic [ENTRIES-1:0]    sel;
  logic                  by_key;
  logic                  full;
  logic                  do_write;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] value_rd;

  assign req_key   = KEY_BITS'(req_i.key);
  assign req_value = VALUE_BITS'(req_i.value);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_hit_raw[i]   = valid_q[i] && (key_q[i] == req_key);
      value_hit_raw[i] = valid_q[i] && (value_q[i] == req_value);
    end
  end

  // Keep the lowest match only: isolate the lowest set bit
  assign key_hit   = key_hit_raw & (~key_hit_raw + ENTRIES'(1));
  assign value_hit = value_hit_raw & (~value_hit_raw + ENTRIES'(1));

  // Insert frees both matches first, then takes the lowest free slot
  assign valid_freed = valid_q & ~key_hit & ~value_hit;
  assign free_vec    = ~valid_freed;
  assign slot        = free_vec & (~free_vec + ENTRIES'(1));
  assign full        = (free_vec == '0);

  assign by_key = (req_i.op == OP_GET_KEY) || (req_i.op == OP_REMOVE_KEY);
  assign sel    = by_key ? key_hit : value_hit;

  always_comb begin
    key_rd   = '0;
    value_rd = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      key_rd   = key_rd | (key_q[i] & {KEY_BITS{sel[i]}});
      value_rd = value_rd | (value_q[i] & {VALUE_BITS{sel[i]}});
    end
  end

  always_comb begin
    valid_d  = valid_q;
    do_write = 1'b0;
    rsp_o    = '{status: ST_MISS, key: '0, value: '0};
    unique case (op_e'(req_i.op))
      OP_INSERT: begin
        if (full) begin
          rsp_o.status = ST_FULL;
        end else begin
          rsp_o.status = ST_OK;
          valid_d      = valid_freed | slot;
          do_write     = 1'b1;
        end
      end
      OP_GET_KEY, OP_GET_VALUE: begin
        if (sel != '0) begin
          rsp_o = '{status: ST_OK, key: KeyInBits'(key_rd), value: ValueInBits'(value_rd)};
        end
      end
      OP_REMOVE_KEY, OP_REMOVE_VALUE: begin
        if (sel != '0) begin
          rsp_o   = '{status: ST_OK, key: KeyInBits'(key_rd), value: ValueInBits'(value_rd)};
          valid_d = valid_q & ~sel;
        end
      end
      default: begin
        rsp_o = '{status: ST_MISS, key: '0, value: '0};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (en_i && do_write && slot[i]) begin
        key_q[i]   <= req_key;
        value_q[i] <= req_value;
      end
    end
  end

  // Keys and values stay unique among valid entries
  `BMT_ASSERT(a_key_unique, clk_i, rst_ni, $onehot0(key_hit_raw))
  `BMT_ASSERT(a_value_unique, clk_i, rst_ni, $onehot0(value_hit_raw))
  `BMT_ASSERT(a_full_only_when_all_valid, clk_i, rst_ni,
              (en_i && rsp_o.status == ST_FULL) |-> (&valid_q))
  `BMT_ASSERT(a_full_leaves_table, clk_i, rst_ni,
              (en_i && rsp_o.status == ST_FULL) |=> $stable(valid_q))

endmodule

`default_nettype wire

// ----- hw/rtl/bidirectional_map_table.sv -----
// ----------------------------------------------------------------------------
// Bidirectional map table
// One-to-one key/value table with insert, lookup and removal in both directions.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries operation, key_in and value_in; rsp_o returns status,
//   key_out and value_out, one response per request, in request order.
//   A request transfer lands in an input register; from there it goes
//   through the CAM match against all entries, and when it advances the
//   table updates and the response is captured in the output register.
//   Throughput: one request per cycle while the output is not stalled, set
//   by the parallel compare and update of all entries.
//   Stall: while rsp_o.ready is low with a response held, the input register
//   still fills once; then req_i.ready drops until the response transfers.
//   Reset: all entries become invalid at once, the table is empty, and no
//   clearing pass is needed; both registers are emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module bidirectional_map_table #(
  parameter int ENTRIES    = bmt_pkg::EntriesDefault,
  parameter int KEY_BITS   = bmt_pkg::KeyBitsDefault,
  parameter int VALUE_BITS = bmt_pkg::ValueBitsDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bmt_req_if.sink    req_i,
  bmt_rsp_if.source  rsp_o
);
  import bmt_pkg::*;

  logic in_valid_q;
  req_t req_q;
  logic out_valid_q;
  rsp_t rsp_q;
  rsp_t cam_rsp;
  logic advance;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= '{op: req_i.operation, key: req_i.key_in, value: req_i.value_in};
    end
  end

  bmt_cam #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_cam (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (req_q),
    .rsp_o  (cam_rsp)
  );

  // Hold the response until it transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= cam_rsp;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = rsp_q.status;
  assign rsp_o.key_out   = rsp_q.key;
  assign rsp_o.value_out = rsp_q.value;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Bidirectional map table testbench
// Walks a short table of directed requests, then random request streams
// under three idle patterns, and checks every response against a fixed
// expectation or a local model of the one-to-one key/value table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bmt_pkg::*;

  localparam int Entries    = EntriesDefault;
  localparam int KeyBits    = KeyBitsDefault;
  localparam int ValueBits  = ValueBitsDefault;
  localparam int PoolSize   = 24;
  localparam int PhaseItems = 584;
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 80;
  localparam int HoldAfter  = 300;

  // Operation codes the block does not define
  localparam logic [OpBits-1:0] OpUnusedFirst = OpBits'(OP_REMOVE_VALUE + 1);
  localparam logic [OpBits-1:0] OpUnusedLast  = '1;

  typedef struct {
    logic [OpBits-1:0]      op;
    logic [KeyInBits-1:0]   key;
    logic [ValueInBits-1:0] value;
    bit                     known;
    rsp_t                   rsp;
  } probe_t;

  localparam int NumProbes = 12;

  logic clk_i;
  logic rst_ni;

  bmt_req_if req ();
  bmt_rsp_if rsp ();

  bidirectional_map_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Local copy of the table
  bit                   live_valid [Entries];
  logic [KeyBits-1:0]   live_key   [Entries];
  logic [ValueBits-1:0] live_value [Entries];

  rsp_t pending_rsp_q [$];

  logic [KeyInBits-1:0]   key_pool   [PoolSize];
  logic [ValueInBits-1:0] value_pool [PoolSize];

  probe_t probes [NumProbes];

  int  src_idle_pct;
  int  sink_idle_pct;
  int  rsp_count;
  int  hold_left;
  bit  hold_done;
  int  quiet_cycles;
  bit  mismatch_seen;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int find_key(logic [KeyBits-1:0] k);
    for (int i = 0; i < Entries; i++) begin
      if (live_valid[i] && live_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int find_value(logic [ValueBits-1:0] v);
    for (int i = 0; i < Entries; i++) begin
      if (live_valid[i] && live_value[i] == v) return i;
    end
    return -1;
  endfunction

  // Apply one request to the local table and return the response it gives
  function automatic rsp_t map_apply(logic [OpBits-1:0] op, logic [KeyInBits-1:0] key_in,
                                     logic [ValueInBits-1:0] value_in);
    rsp_t                 r;
    int                   hit;
    bit                   placed;
    logic [KeyBits-1:0]   k;
    logic [ValueBits-1:0] v;
    k = key_in[KeyBits-1:0];
    v = value_in[ValueBits-1:0];
    r = '{status: ST_MISS, key: '0, value: '0};
    hit = -1;
    case (op)
      OP_INSERT: begin
        hit = find_key(k);
        if (hit >= 0) live_valid[hit] = 1'b0;
        hit = find_value(v);
        if (hit >= 0) live_valid[hit] = 1'b0;
        placed = 1'b0;
        for (int i = 0; i < Entries; i++) begin
          if (!placed && !live_valid[i]) begin
            live_valid[i] = 1'b1;
            live_key[i]   = k;
            live_value[i] = v;
            placed        = 1'b1;
          end
        end
        r.status = placed ? ST_OK : ST_FULL;
        return r;
      end
      OP_GET_KEY, OP_REMOVE_KEY:     hit = find_key(k);
      OP_GET_VALUE, OP_REMOVE_VALUE: hit = find_value(v);
      default: ;
    endcase
    if (hit >= 0) begin
      r.status = ST_OK;
      r.key    = KeyInBits'(live_key[hit]);
      r.value  = ValueInBits'(live_value[hit]);
      if (op == OP_REMOVE_KEY || op == OP_REMOVE_VALUE) live_valid[hit] = 1'b0;
    end
    return r;
  endfunction

  // Offer one request, wait for its transfer, and queue the response it owes
  task automatic issue_request(input logic [OpBits-1:0] op, input logic [KeyInBits-1:0] k,
                               input logic [ValueInBits-1:0] v, input bit known,
                               input rsp_t known_rsp);
    rsp_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid     = 1'b1;
    req.operation = op;
    req.key_in    = k;
    req.value_in  = v;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predicted = map_apply(op, k, v);
    if (known) predicted = known_rsp;
    pending_rsp_q = {pending_rsp_q, predicted};
  endtask

  task automatic issue_random();
    logic [OpBits-1:0]      op;
    logic [KeyInBits-1:0]   k;
    logic [ValueInBits-1:0] v;
    int                     r;
    int                     live [$];
    int                     pick;
    r = $urandom_range(99);
    if (r < 36)      op = OP_INSERT;
    else if (r < 51) op = OP_GET_KEY;
    else if (r < 66) op = OP_GET_VALUE;
    else if (r < 79) op = OP_REMOVE_KEY;
    else if (r < 92) op = OP_REMOVE_VALUE;
    else op = OpBits'(OpUnusedFirst + $urandom_range(OpUnusedLast - OpUnusedFirst));
    // Mostly draw from a small pool so entries collide and the table fills
    k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(PoolSize - 1)]
                                  : KeyInBits'($urandom);
    v = ($urandom_range(99) < 85) ? value_pool[$urandom_range(PoolSize - 1)]
                                  : ValueInBits'($urandom);
    // Aim most lookups and removals at live entries
    if (op != OP_INSERT && $urandom_range(99) < 60) begin
      for (int i = 0; i < Entries; i++) begin
        if (live_valid[i]) live = {live, i};
      end
      if (live.size() > 0) begin
        pick = live[$urandom_range(live.size() - 1)];
        k    = KeyInBits'(live_key[pick]);
        v    = ValueInBits'(live_value[pick]);
      end
    end
    issue_request(op, k, v, 1'b0, '{status: ST_MISS, key: '0, value: '0});
  endtask

  // Response side: random stalls plus one long hold-off to back up the input
  initial begin
    rsp.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp.ready = 1'b0;
        hold_left--;
      end else if (!hold_done && rsp_count >= HoldAfter) begin
        rsp.ready = 1'b0;
        hold_left = HoldCycles - 1;
        hold_done = 1'b1;
      end else begin
        rsp.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && rsp.valid && rsp.ready) begin
      rsp_count++;
      if (pending_rsp_q.size() == 0) begin
        $error("response transfer with nothing outstanding");
        mismatch_seen = 1'b1;
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        if (rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
          mismatch_seen = 1'b1;
        end
        if (rsp.key_out !== exp_rsp.key) begin
          $error("key_out: expected %h, got %h", exp_rsp.key, rsp.key_out);
          mismatch_seen = 1'b1;
        end
        if (rsp.value_out !== exp_rsp.value) begin
          $error("value_out: expected %h, got %h", exp_rsp.value, rsp.value_out);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run once transfers stop on both sides
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    req.valid     = 1'b0;
    req.operation = OP_INSERT;
    req.key_in    = '0;
    req.value_in  = '0;
    src_idle_pct  = 6;
    sink_idle_pct = 57;
    rsp_count     = 0;
    quiet_cycles  = 0;
    mismatch_seen = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      live_valid[i] = 1'b0;
      live_key[i]   = '0;
      live_value[i] = '0;
    end
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i]   = KeyInBits'($urandom);
      value_pool[i] = ValueInBits'($urandom);
    end
    key_pool[0]   = '0;
    key_pool[1]   = '1;
    value_pool[0] = '0;
    value_pool[1] = '1;

    probes = '{
      '{OP_GET_KEY,      16'h0000, 16'h0000, 1'b1, '{ST_MISS, 16'h0000, 16'h0000}},
      '{OP_GET_VALUE,    16'h0000, 16'hFFFF, 1'b1, '{ST_MISS, 16'h0000, 16'h0000}},
      '{OP_REMOVE_KEY,   16'hFFFF, 16'h0000, 1'b1, '{ST_MISS, 16'h0000, 16'h0000}},
      '{OpUnusedFirst,   16'hFFFF, 16'hFFFF, 1'b1, '{ST_MISS, 16'h0000, 16'h0000}},
      '{OpUnusedLast,    16'hFFFF, 16'hFFFF, 1'b1, '{ST_MISS, 16'h0000, 16'h0000}},
      '{OP_INSERT,       16'h0000, 16'hFFFF, 1'b1, '{ST_OK,   16'h0000, 16'h0000}},
      '{OP_INSERT,       16'hFFFF, 16'h0000, 1'b1, '{ST_OK,   16'h0000, 16'h0000}},
      '{OP_GET_KEY,      16'hFFFF, 16'h1234, 1'b1, '{ST_OK,   16'hFFFF, 16'h0000}},
      '{OP_GET_VALUE,    16'h4321, 16'hFFFF, 1'b1, '{ST_OK,   16'h0000, 16'hFFFF}},
      '{OP_INSERT,       16'h0000, 16'hFFFF, 1'b1, '{ST_OK,   16'h0000, 16'h0000}},
      // Key of one entry and value of the other: both drop, one pair stays
      '{OP_INSERT,       16'h0000, 16'h0000, 1'b0, '{ST_OK,   16'h0000, 16'h0000}},
      '{OP_REMOVE_VALUE, 16'h5555, 16'h0000, 1'b0, '{ST_OK,   16'h0000, 16'h0000}}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (probes[i]) begin
      issue_request(probes[i].op, probes[i].key, probes[i].value, probes[i].known,
                    probes[i].rsp);
    end
    // Fill every slot, then insert a fresh pair into the full table
    for (int i = 0; i < Entries; i++) begin
      issue_request(OP_INSERT, KeyInBits'(16'h0100 + i), ValueInBits'(16'h8000 + i),
                    1'b0, '{ST_OK, 16'h0000, 16'h0000});
    end
    issue_request(OP_INSERT, 16'h7777, 16'h7777, 1'b0, '{ST_OK, 16'h0000, 16'h0000});
    issue_request(OP_INSERT, 16'h0105, 16'h1234, 1'b0, '{ST_OK, 16'h0000, 16'h0000});
    issue_request(OP_GET_VALUE, 16'h0000, 16'h1234, 1'b0, '{ST_OK, 16'h0000, 16'h0000});

    repeat (PhaseItems) issue_random();
    src_idle_pct  = 57;
    sink_idle_pct = 6;
    repeat (PhaseItems) issue_random();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (PhaseItems) issue_random();

    @(negedge clk_i);
    req.valid = 1'b0;
    while (pending_rsp_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (!mismatch_seen) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
